/* sv/cht_pkg.sv */
// ----------------------------------------------------------------------------
// Chained hash table package
// Sizes, operation and status codes, and the command/status structs that
// pass between the sequencer, the node store and the free list.
// ----------------------------------------------------------------------------
package cht_pkg;

   localparam int NUM_BUCKETS = 8;
   localparam int POOL_DEPTH  = 64;
   localparam int KEY_WIDTH   = 32;
   localparam int VALUE_WIDTH = 32;

   localparam int BUCKET_BITS = $clog2(NUM_BUCKETS);
   localparam int NODE_BITS   = $clog2(POOL_DEPTH);
   localparam int LINK_BITS   = $clog2(POOL_DEPTH + 1);
   localparam int COUNT_BITS  = $clog2(POOL_DEPTH + 1);

   localparam int FUNC_WIDTH   = 1;
   localparam int STATUS_WIDTH = 2;
   localparam int INDEX_WIDTH  = 3;
   localparam int FILL_WIDTH   = 7;
   localparam int COUNT_WIDTH  = 7;

   localparam logic [LINK_BITS-1:0] NULL_LINK = LINK_BITS'(POOL_DEPTH);

   localparam logic [FUNC_WIDTH-1:0] FUNC_INSERT = 1'b0;
   localparam logic [FUNC_WIDTH-1:0] FUNC_ERASE  = 1'b1;

   localparam logic [STATUS_WIDTH-1:0] STATUS_DONE      = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_POOL_FULL = 2'd2;

   typedef struct packed {
      logic                   rd_en;
      logic [NODE_BITS-1:0]   rd_addr;
      logic                   wr_en;
      logic                   wr_all;
      logic [NODE_BITS-1:0]   wr_addr;
      logic [KEY_WIDTH-1:0]   wr_key;
      logic [VALUE_WIDTH-1:0] wr_value;
      logic [LINK_BITS-1:0]   wr_link;
   } node_cmd_type;

   typedef struct packed {
      logic                 pop_rd;
      logic                 pop;
      logic                 push;
      logic [NODE_BITS-1:0] push_node;
   } free_cmd_type;

   typedef struct packed {
      logic                 empty;
      logic                 full;
      logic [NODE_BITS-1:0] pop_node;
   } free_stat_type;

endpackage

/* sv/chained_hash_table.sv */
// ----------------------------------------------------------------------------
// Chained hash table
// Separate chaining hash table over a fixed node pool, one request at a time.
//
// A request (req_func, req_key, req_value) is taken on req_valid && req_ready.
// The bucket is the key modulo the bucket count. Insert pops a free node and
// links it at the head of the bucket chain; erase walks the chain and unlinks
// the first node with an equal key. Each request gives one response with the
// status, bucket, bucket fill and total entry count after the operation.
// An insert passes through S_POP and S_DONE; pool full goes straight to S_DONE.
// Erase spends one S_CHECK state per chain node visited, set by the single
// registered read port of the node store; an empty bucket goes to S_DONE.
// req_ready returns in the same cycle as rsp_valid, so a new request is
// taken only once the last one is through.
// req_ready is high only while no request is in work. A finished response
// waits in the output register while rsp_ready is low, and the next request
// can already be taken; the sequencer then holds its result until the
// output register frees. Reset empties all buckets and frees every node;
// no clearing pass is needed, the block is ready in the cycle after reset.
// ----------------------------------------------------------------------------
module chained_hash_table
   import cht_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [FUNC_WIDTH-1:0]   req_func,
   input  logic [KEY_WIDTH-1:0]    req_key,
   input  logic [VALUE_WIDTH-1:0]  req_value,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [STATUS_WIDTH-1:0] rsp_status,
   output logic [INDEX_WIDTH-1:0]  rsp_bucket_index,
   output logic [FILL_WIDTH-1:0]   rsp_bucket_fill,
   output logic [COUNT_WIDTH-1:0]  rsp_entry_count
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_POP   = 2'd1;
   localparam logic [1:0] S_CHECK = 2'd2;
   localparam logic [1:0] S_DONE  = 2'd3;

   logic [1:0]              state_ff, state_in;
   logic [KEY_WIDTH-1:0]    key_ff, key_in;
   logic [VALUE_WIDTH-1:0]  value_ff, value_in;
   logic [BUCKET_BITS-1:0]  bucket_ff, bucket_in;
   logic [NODE_BITS-1:0]    cur_ff, cur_in;
   logic [LINK_BITS-1:0]    prev_ff, prev_in;
   logic [STATUS_WIDTH-1:0] status_ff, status_in;
   logic [LINK_BITS-1:0]    head_ff [NUM_BUCKETS];
   logic [LINK_BITS-1:0]    head_in [NUM_BUCKETS];
   logic [COUNT_BITS-1:0]   len_ff  [NUM_BUCKETS];
   logic [COUNT_BITS-1:0]   len_in  [NUM_BUCKETS];
   logic [COUNT_BITS-1:0]   total_ff, total_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [STATUS_WIDTH-1:0] rsp_status_ff, rsp_status_in;
   logic [INDEX_WIDTH-1:0]  rsp_index_ff, rsp_index_in;
   logic [FILL_WIDTH-1:0]   rsp_fill_ff, rsp_fill_in;
   logic [COUNT_WIDTH-1:0]  rsp_count_ff, rsp_count_in;

   node_cmd_type           node_cmd;
   logic [KEY_WIDTH-1:0]   rd_key;
   logic [LINK_BITS-1:0]   rd_link;
   free_cmd_type           free_cmd;
   free_stat_type          free_stat;
   logic [BUCKET_BITS-1:0] req_bucket;
   logic [LINK_BITS-1:0]   req_head;

   cht_node_mem u_node_mem (
      .clock   (clock),
      .cmd     (node_cmd),
      .rd_key  (rd_key),
      .rd_link (rd_link)
   );

   cht_free_list u_free_list (
      .clock (clock),
      .reset (reset),
      .cmd   (free_cmd),
      .stat  (free_stat)
   );

   assign req_ready  = (state_ff == S_IDLE);
   assign req_bucket = BUCKET_BITS'(req_key % NUM_BUCKETS);
   assign req_head   = head_ff[req_bucket];

   always_comb begin
      state_in  = state_ff;
      key_in    = key_ff;
      value_in  = value_ff;
      bucket_in = bucket_ff;
      cur_in    = cur_ff;
      prev_in   = prev_ff;
      status_in = status_ff;
      head_in   = head_ff;
      len_in    = len_ff;
      total_in  = total_ff;

      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_fill_in   = rsp_fill_ff;
      rsp_count_in  = rsp_count_ff;

      node_cmd          = '0;
      node_cmd.wr_key   = key_ff;
      node_cmd.wr_value = value_ff;
      free_cmd          = '0;
      free_cmd.push_node = cur_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               key_in    = req_key;
               value_in  = req_value;
               bucket_in = req_bucket;
               prev_in   = NULL_LINK;
               if (req_func == FUNC_INSERT) begin
                  if (free_stat.empty) begin
                     status_in = STATUS_POOL_FULL;
                     state_in  = S_DONE;
                  end else begin
                     free_cmd.pop_rd = 1'b1;
                     state_in        = S_POP;
                  end
               end else if (req_head >= LINK_BITS'(POOL_DEPTH)) begin
                  status_in = STATUS_NOT_FOUND;
                  state_in  = S_DONE;
               end else begin
                  node_cmd.rd_en   = 1'b1;
                  node_cmd.rd_addr = req_head[NODE_BITS-1:0];
                  cur_in           = req_head[NODE_BITS-1:0];
                  state_in         = S_CHECK;
               end
            end
         end
         S_POP: begin
            node_cmd.wr_en    = 1'b1;
            node_cmd.wr_all   = 1'b1;
            node_cmd.wr_addr  = free_stat.pop_node;
            node_cmd.wr_link  = head_ff[bucket_ff];
            head_in[bucket_ff] = LINK_BITS'(free_stat.pop_node);
            len_in[bucket_ff]  = len_ff[bucket_ff] + COUNT_BITS'(1);
            total_in           = total_ff + COUNT_BITS'(1);
            free_cmd.pop       = 1'b1;
            status_in          = STATUS_DONE;
            state_in           = S_DONE;
         end
         S_CHECK: begin
            if (rd_key == key_ff) begin
               if (prev_ff == NULL_LINK) begin
                  head_in[bucket_ff] = rd_link;
               end else begin
                  node_cmd.wr_en   = 1'b1;
                  node_cmd.wr_addr = prev_ff[NODE_BITS-1:0];
                  node_cmd.wr_link = rd_link;
               end
               if (len_ff[bucket_ff] != '0) begin
                  len_in[bucket_ff] = len_ff[bucket_ff] - COUNT_BITS'(1);
               end
               if (total_ff != '0) begin
                  total_in = total_ff - COUNT_BITS'(1);
               end
               free_cmd.push = !free_stat.full;
               status_in     = STATUS_DONE;
               state_in      = S_DONE;
            end else if (rd_link < LINK_BITS'(POOL_DEPTH)) begin
               node_cmd.rd_en   = 1'b1;
               node_cmd.rd_addr = rd_link[NODE_BITS-1:0];
               prev_in          = LINK_BITS'(cur_ff);
               cur_in           = rd_link[NODE_BITS-1:0];
            end else begin
               status_in = STATUS_NOT_FOUND;
               state_in  = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_index_in  = INDEX_WIDTH'(bucket_ff);
               rsp_fill_in   = FILL_WIDTH'(len_ff[bucket_ff]);
               rsp_count_in  = COUNT_WIDTH'(total_ff);
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         total_ff     <= '0;
         for (int i = 0; i < NUM_BUCKETS; i++) begin
            head_ff[i] <= NULL_LINK;
            len_ff[i]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         total_ff     <= total_in;
         head_ff      <= head_in;
         len_ff       <= len_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff        <= key_in;
      value_ff      <= value_in;
      bucket_ff     <= bucket_in;
      cur_ff        <= cur_in;
      prev_ff       <= prev_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_fill_ff   <= rsp_fill_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_bucket_index = rsp_index_ff;
   assign rsp_bucket_fill  = rsp_fill_ff;
   assign rsp_entry_count  = rsp_count_ff;

endmodule

/* sv/cht_node_mem.sv */
// ----------------------------------------------------------------------------
// Node store
// Key, value and link memories of the node pool; one write port and one
// registered read port for key and link.
// ----------------------------------------------------------------------------
module cht_node_mem
   import cht_pkg::*;
(
   input  logic                 clock,
   input  node_cmd_type         cmd,
   output logic [KEY_WIDTH-1:0] rd_key,
   output logic [LINK_BITS-1:0] rd_link
);

   logic [KEY_WIDTH-1:0]   key_mem   [POOL_DEPTH];
   logic [VALUE_WIDTH-1:0] value_mem [POOL_DEPTH];
   logic [LINK_BITS-1:0]   link_mem  [POOL_DEPTH];

   logic [KEY_WIDTH-1:0] rd_key_ff;
   logic [LINK_BITS-1:0] rd_link_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         link_mem[cmd.wr_addr] <= cmd.wr_link;
         if (cmd.wr_all) begin
            key_mem[cmd.wr_addr]   <= cmd.wr_key;
            value_mem[cmd.wr_addr] <= cmd.wr_value;
         end
      end
      if (cmd.rd_en) begin
         rd_key_ff  <= key_mem[cmd.rd_addr];
         rd_link_ff <= link_mem[cmd.rd_addr];
      end
   end

   assign rd_key  = rd_key_ff;
   assign rd_link = rd_link_ff;

endmodule

/* sv/cht_free_list.sv */
// ----------------------------------------------------------------------------
// Free node list
// Stack of free node indexes. Entries never written read as their reset
// index, tracked with one valid bit per entry.
// ----------------------------------------------------------------------------
module cht_free_list
   import cht_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  free_cmd_type  cmd,
   output free_stat_type stat
);

   logic [NODE_BITS-1:0] stack_mem [POOL_DEPTH];
   logic [POOL_DEPTH-1:0] written_ff, written_in;
   logic [LINK_BITS-1:0]  top_ff, top_in;
   logic [NODE_BITS-1:0]  rd_addr;
   logic [NODE_BITS-1:0]  wr_addr;
   logic [NODE_BITS-1:0]  rd_data_ff;
   logic [NODE_BITS-1:0]  rd_addr_ff;
   logic                  rd_written_ff;

   assign rd_addr = NODE_BITS'(top_ff - LINK_BITS'(1));
   assign wr_addr = top_ff[NODE_BITS-1:0];

   always_comb begin
      top_in     = top_ff;
      written_in = written_ff;
      if (cmd.pop) begin
         top_in = top_ff - LINK_BITS'(1);
      end else if (cmd.push) begin
         top_in            = top_ff + LINK_BITS'(1);
         written_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff     <= LINK_BITS'(POOL_DEPTH);
         written_ff <= '0;
      end else begin
         top_ff     <= top_in;
         written_ff <= written_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push && !cmd.pop) begin
         stack_mem[wr_addr] <= cmd.push_node;
      end
      if (cmd.pop_rd) begin
         rd_data_ff    <= stack_mem[rd_addr];
         rd_written_ff <= written_ff[rd_addr];
         rd_addr_ff    <= rd_addr;
      end
   end

   assign stat.empty    = (top_ff == '0);
   assign stat.full     = (top_ff >= LINK_BITS'(POOL_DEPTH));
   assign stat.pop_node = rd_written_ff ? rd_data_ff
                                        : NODE_BITS'(POOL_DEPTH - 1) - rd_addr_ff;

endmodule
